FILE: rtl/sv39_page_table_walker_macros.svh
`ifndef SV39_PAGE_TABLE_WALKER_MACROS_SVH
`define SV39_PAGE_TABLE_WALKER_MACROS_SVH

// Clocked check on aclk, off while aresetn is low.
`define PTW_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Implication that holds at the same edge.
`define PTW_ASSERT_IMPL(label, ante, cons, msg) \
    `PTW_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: rtl/sv39ptw_pkg.sv
`default_nettype none

package sv39ptw_pkg;

    localparam int TABLE_PAGES       = 8;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int VA_LIMIT_BITS     = 38;

    localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int VPN_W       = 9;
    localparam int ADDR_W      = PAGE_W + VPN_W;
    localparam int WADDR_EXT_W = ADDR_W + 12;

    localparam int PPN_W   = 44;
    localparam int VA_W    = 39;
    localparam int PA_W    = 56;
    localparam int PTE_W   = 64;
    localparam int FLAGS_W = 10;
    localparam int OFF_W   = 12;

    localparam int PTE_V_BIT   = 0;
    localparam int PTE_U_BIT   = 4;
    localparam int PTE_PPN_LSB = 10;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 72;

    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_TRANSLATE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_VA_LIMIT = 3'd1,
        ST_NO_TABLE = 3'd2,
        ST_BAD_LEAF = 3'd3,
        ST_NOT_USER = 3'd4,
        ST_OUTSIDE  = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        CFG_ROOT_PPN = 1'b0,
        CFG_BASE_PPN = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_HOLD
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/sv39_page_table_walker.sv
`default_nettype none

// Sv39 page-table walker with a local store of TABLE_PAGES table pages (512 x 64-bit PTEs
// each, one synchronous RAM with a registered read). A transfer with tuser 0 writes one
// PTE and returns a result; writes may follow back to back while the output is free. A
// transfer with tuser 1 translates a virtual address. When the walk reaches the leaf
// level, the result follows three dependent PTE reads: one RAM read per level, with
// each read's table check folded into the cycle that returns the previous entry. No new
// transfer is taken until the walk is back in idle. A walk can also stop early at an
// outside or missing table. A VA over the limit is answered like a write, at the
// transfer itself. One finished result can wait at the output while the next transfer
// is taken. After reset a clearing pass zeroes the store (TABLE_PAGES * 512 = 4096
// words), one word per cycle, and s_tready stays low for that pass. Configuration
// writes are taken at any time and should only be made while idle.
module sv39_page_table_walker
    import sv39ptw_pkg::*;
(
    input  wire                      aclk,
    input  wire                      aresetn,

    input  wire                      cfg_valid,
    output logic                     cfg_ready,
    input  wire                      cfg_index,
    input  wire  [PPN_W-1:0]         cfg_data,

    input  wire                      s_tvalid,
    output logic                     s_tready,
    // [11:0] pte_addr, [75:12] pte_value, [114:76] vaddr, [115] require_user, [119:116] zero
    input  wire  [S_TDATA_W-1:0]     s_tdata,
    // [0] command
    input  wire                      s_tuser,

    output logic                     m_tvalid,
    input  wire                      m_tready,
    // [2:0] status, [58:3] phys_addr, [68:59] leaf_flags, [71:69] zero
    output logic [M_TDATA_W-1:0]     m_tdata
);

    logic [PTE_W-1:0]       mem [STORE_WORDS];
    logic [PTE_W-1:0]       rd_data_reg;

    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic [PPN_W-1:0]       root_ppn_reg;
    logic [PPN_W-1:0]       base_ppn_reg;
    logic [VA_W-1:0]        vaddr_reg;
    logic                   req_user_reg;
    logic [1:0]             level_reg;

    logic                   m_tvalid_reg;
    status_t                out_status_reg;
    logic [PA_W-1:0]        out_pa_reg;
    logic [FLAGS_W-1:0]     out_flags_reg;
    status_t                hold_status_reg;
    logic [PA_W-1:0]        hold_pa_reg;
    logic [FLAGS_W-1:0]     hold_flags_reg;

    logic [11:0]            in_pte_addr;
    logic [PTE_W-1:0]       in_pte_value;
    logic [VA_W-1:0]        in_vaddr;
    logic                   in_req_user;
    logic [WADDR_EXT_W-1:0] wr_addr_ext;
    logic                   wr_in_range;
    logic                   va_over;

    logic [PTE_W-1:0]       pte;
    logic [PPN_W-1:0]       pte_ppn;
    logic [PPN_W-1:0]       lookup_ppn;
    logic [PPN_W-1:0]       page_diff;
    logic                   page_out;
    logic [1:0]             rd_level;
    logic [VPN_W-1:0]       vpn;
    logic [ADDR_W-1:0]      rd_addr;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa;
    logic [PTE_W-1:0]       mem_wd;
    logic                   mem_re;

    logic                   res_valid;
    status_t                res_status;
    logic [PA_W-1:0]        res_pa;
    logic [FLAGS_W-1:0]     res_flags;
    logic                   out_free;

    assign cfg_ready = 1'b1;

    assign in_pte_addr  = s_tdata[11:0];
    assign in_pte_value = s_tdata[75:12];
    assign in_vaddr     = s_tdata[114:76];
    assign in_req_user  = s_tdata[115];

    assign wr_addr_ext = WADDR_EXT_W'(in_pte_addr);
    assign wr_in_range = wr_addr_ext < WADDR_EXT_W'(STORE_WORDS);
    assign va_over     = ((VA_W + 1)'(in_vaddr) >> VA_LIMIT_BITS) != '0;

    assign pte        = rd_data_reg;
    assign pte_ppn    = pte[PTE_PPN_LSB +: PPN_W];
    assign lookup_ppn = (state_reg == S_LOOKUP) ? root_ppn_reg : pte_ppn;
    assign page_diff  = lookup_ppn - base_ppn_reg;
    assign page_out   = page_diff >= PPN_W'(TABLE_PAGES);
    assign rd_level   = (state_reg == S_LOOKUP) ? 2'd2 : level_reg - 2'd1;
    assign rd_addr    = {page_diff[PAGE_W-1:0], vpn};

    always_comb begin
        unique case (rd_level)
            2'd2:    vpn = vaddr_reg[38:30];
            2'd1:    vpn = vaddr_reg[29:21];
            default: vpn = vaddr_reg[20:12];
        endcase
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // datapath control and result
    always_comb begin
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = clr_addr_reg;
        mem_wd     = '0;
        mem_re     = 1'b0;
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_pa     = '0;
        res_flags  = '0;
        unique case (state_reg)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == CMD_WRITE) begin
                        mem_we    = wr_in_range;
                        mem_wa    = wr_addr_ext[ADDR_W-1:0];
                        mem_wd    = in_pte_value;
                        res_valid = 1'b1;
                    end else if (va_over) begin
                        res_valid  = 1'b1;
                        res_status = ST_VA_LIMIT;
                    end
                end
            end
            S_LOOKUP: begin
                if (page_out) begin
                    res_valid  = 1'b1;
                    res_status = ST_OUTSIDE;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_CHECK: begin
                priority if (!pte[PTE_V_BIT]) begin
                    res_valid  = 1'b1;
                    res_status = (level_reg != 2'd0) ? ST_NO_TABLE : ST_BAD_LEAF;
                end else if (level_reg == 2'd0) begin
                    res_valid = 1'b1;
                    if (req_user_reg && !pte[PTE_U_BIT]) begin
                        res_status = ST_NOT_USER;
                    end else begin
                        res_pa    = {pte_ppn, vaddr_reg[OFF_W-1:0]};
                        res_flags = pte[FLAGS_W-1:0];
                    end
                end else if (page_out) begin
                    res_valid  = 1'b1;
                    res_status = ST_OUTSIDE;
                end else begin
                    mem_re = 1'b1;
                end
            end
            S_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(STORE_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    priority if (res_valid && out_free) state_next = S_IDLE;
                    else if (res_valid)                 state_next = S_HOLD;
                    else                                state_next = S_LOOKUP;
                end
            end
            S_LOOKUP, S_CHECK: begin
                priority if (res_valid && out_free) state_next = S_IDLE;
                else if (res_valid)                 state_next = S_HOLD;
                else                                state_next = S_CHECK;
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_addr_reg <= '0;
            root_ppn_reg <= '0;
            base_ppn_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ROOT_PPN: root_ppn_reg <= cfg_data;
                    CFG_BASE_PPN: base_ppn_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            m_tvalid_reg <= (m_tvalid_reg && !m_tready) || (res_valid && out_free) ||
                            (state_reg == S_HOLD && out_free);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            vaddr_reg    <= in_vaddr;
            req_user_reg <= in_req_user;
        end
        if (mem_re) begin
            level_reg <= rd_level;
        end
        if (res_valid && out_free) begin
            out_status_reg <= res_status;
            out_pa_reg     <= res_pa;
            out_flags_reg  <= res_flags;
        end else if (state_reg == S_HOLD && out_free) begin
            out_status_reg <= hold_status_reg;
            out_pa_reg     <= hold_pa_reg;
            out_flags_reg  <= hold_flags_reg;
        end
        if (res_valid && !out_free) begin
            hold_status_reg <= res_status;
            hold_pa_reg     <= res_pa;
            hold_flags_reg  <= res_flags;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_flags_reg, out_pa_reg, out_status_reg};

`include "sv39_page_table_walker_macros.svh"

    `PTW_ASSERT_IMPL(a_hold_needs_busy_out, state_reg == S_HOLD, m_tvalid_reg,
                     "hold with empty output")
    `PTW_ASSERT_IMPL(a_fail_clears_payload, m_tvalid_reg && out_status_reg != ST_OK,
                     out_pa_reg == '0 && out_flags_reg == '0,
                     "failed result carries payload")
    `PTW_ASSERT_IMPL(a_lookup_after_idle, state_reg == S_LOOKUP,
                     $past(state_reg) == S_IDLE, "walk not started from idle")
    `PTW_ASSERT_IMPL(a_check_level_range, state_reg == S_CHECK, level_reg != 2'd3,
                     "walk level out of range")

endmodule

`default_nettype wire
